// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk with rst as disable.
`define VWS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, checked on clk with rst as disable.
`define VWS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ===== rtl/vws_pkg.sv =====
// Types, sizes, codes and helpers for the voxel weighted sampler.
package vws_pkg;

  localparam int AXIS_MAX    = 32;
  localparam int WEIGHT_BITS = 16;
  localparam int AXIS_BITS   = $clog2(AXIS_MAX);
  localparam int DIM_BITS    = 6;
  localparam int ADDR_BITS   = 3 * AXIS_BITS;
  localparam int STORE_DEPTH = AXIS_MAX * AXIS_MAX * AXIS_MAX;
  localparam int TOTAL_BITS  = WEIGHT_BITS + ADDR_BITS;
  localparam int RAND_BITS   = 32;
  localparam int PROD_BITS   = RAND_BITS + TOTAL_BITS;

  localparam int S_DATA_RAW  = 3 * AXIS_BITS + 16 + RAND_BITS;
  localparam int S_DATA_BITS = ((S_DATA_RAW + 7) / 8) * 8;
  localparam int M_DATA_RAW  = 3 * AXIS_BITS;
  localparam int M_DATA_BITS = ((M_DATA_RAW + 7) / 8) * 8;

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DIM_X = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DIM_Y = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DIM_Z = 2'd2;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_DRAW  = 1'b1;

  typedef struct packed {
    logic                   action;
    logic [AXIS_BITS-1:0]   x;
    logic [AXIS_BITS-1:0]   y;
    logic [AXIS_BITS-1:0]   z;
    logic [WEIGHT_BITS-1:0] weight;
    logic [RAND_BITS-1:0]   rnd;
  } item_t;

  typedef struct packed {
    logic [AXIS_BITS-1:0] x;
    logic [AXIS_BITS-1:0] y;
    logic [AXIS_BITS-1:0] z;
    logic                 zero;
  } res_t;

  // highest in-use index on each axis
  typedef struct packed {
    logic [AXIS_BITS-1:0] lx;
    logic [AXIS_BITS-1:0] ly;
    logic [AXIS_BITS-1:0] lz;
  } dims_t;

  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctl_t;

  typedef struct packed {
    logic clearing;
    logic idle;
    logic done;
  } seq_stat_t;

  // zero acts as one voxel, anything past the grid acts as the full axis
  function automatic logic [AXIS_BITS-1:0] dim_last(input logic [DIM_BITS-1:0] d);
    logic [AXIS_BITS-1:0] r;
    if (d == '0) begin
      r = '0;
    end else if (d > DIM_BITS'(AXIS_MAX)) begin
      r = AXIS_BITS'(AXIS_MAX - 1);
    end else begin
      r = AXIS_BITS'(d - 1'b1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/voxel_weighted_sampler.sv =====
// Voxel weighted sampler: 32x32x32 weight grid with cumulative-sum selection.
// A write item leaves the sampler idle and ready. A draw item reads all N voxels (N = product of
// effective dimensions, at most 32768) to total the grid, scales the total, reads up to N voxels
// to find the pick and then loads the result register; tvalid rises with that load and the next
// item is taken after it. A held result register stalls that load and the input with it.
// Reset rst is synchronous, active high; a clearing pass follows, taking no items.
`include "assert_macros.svh"

module voxel_weighted_sampler (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // voxel_x, voxel_y, voxel_z, weight, random_fraction, zero pad
  input  logic [vws_pkg::S_DATA_BITS-1:0]  s_axis_tdata,
  // action
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pick_x, pick_y, pick_z, zero pad
  output logic [vws_pkg::M_DATA_BITS-1:0]  m_axis_tdata,
  // zero_total
  output logic                             m_axis_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [vws_pkg::DIM_BITS-1:0]     cfg_data
);
  import vws_pkg::*;

  localparam int OFS_Y = AXIS_BITS;
  localparam int OFS_Z = 2 * AXIS_BITS;
  localparam int OFS_W = 3 * AXIS_BITS;
  localparam int OFS_R = OFS_W + 16;

  logic [DIM_BITS-1:0] dim_x, dim_y, dim_z;
  item_t               item;
  dims_t               dims;
  res_t                res;
  seq_stat_t           stat;
  logic                out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_x <= DIM_BITS'(AXIS_MAX);
      dim_y <= DIM_BITS'(AXIS_MAX);
      dim_z <= DIM_BITS'(AXIS_MAX);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIM_X: dim_x <= cfg_data;
        CFG_DIM_Y: dim_y <= cfg_data;
        CFG_DIM_Z: dim_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dims.lx = dim_last(dim_x);
  assign dims.ly = dim_last(dim_y);
  assign dims.lz = dim_last(dim_z);

  assign item.action = s_axis_tuser;
  assign item.x      = s_axis_tdata[AXIS_BITS-1:0];
  assign item.y      = s_axis_tdata[OFS_Y +: AXIS_BITS];
  assign item.z      = s_axis_tdata[OFS_Z +: AXIS_BITS];
  assign item.weight = WEIGHT_BITS'(s_axis_tdata[OFS_W +: 16]);
  assign item.rnd    = s_axis_tdata[OFS_R +: RAND_BITS];

  assign out_load = stat.done && (!m_axis_tvalid || m_axis_tready);

  vws_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .item     (item),
    .dims     (dims),
    .res      (res),
    .res_ack  (out_load),
    .stat     (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= M_DATA_BITS'({res.z, res.y, res.x});
        m_axis_tuser  <= res.zero;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  `VWS_ASSERT_NXT(a_draw_blocks_input, s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_DRAW), !s_axis_tready)
  `VWS_ASSERT_IMP(a_zero_total_picks_origin, m_axis_tvalid && m_axis_tuser, m_axis_tdata[M_DATA_RAW-1:0] == '0)
  `VWS_ASSERT_IMP(a_no_result_while_clearing, stat.clearing, !m_axis_tvalid && !s_axis_tready)

endmodule

// ===== rtl/vws_ram.sv =====
// Single-port-write, single-port-read RAM with registered read data.
module vws_ram #(
  parameter int ADDR_BITS = 15,
  parameter int DATA_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/vws_accum.sv =====
// Shared accumulate and compare unit used by both scan passes.
module vws_accum (
  input  logic                               clk,
  input  vws_pkg::acc_ctl_t                  ctl,
  input  logic [vws_pkg::WEIGHT_BITS-1:0]    data,
  input  logic [vws_pkg::TOTAL_BITS-1:0]     thresh,
  output logic [vws_pkg::TOTAL_BITS-1:0]     sum,
  output logic                               hit
);
  import vws_pkg::*;

  logic [TOTAL_BITS-1:0] acc;

  assign sum = acc + TOTAL_BITS'(data);
  assign hit = (sum >= thresh);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.add) begin
      acc <= sum;
    end
  end

endmodule

// ===== rtl/vws_seq.sv =====
// Sequencer: clear pass, weight writes, sum pass, scaling and search pass.
module vws_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  vws_pkg::item_t  item,
  input  vws_pkg::dims_t  dims,
  output vws_pkg::res_t   res,
  input  logic            res_ack,
  output vws_pkg::seq_stat_t stat
);
  import vws_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SUM, ST_MUL, ST_SEARCH, ST_DONE
  } state_t;

  state_t                 state;
  logic [ADDR_BITS-1:0]   clr_addr;
  logic                   issuing;
  logic [AXIS_BITS-1:0]   cx, cy, cz;
  logic                   rd_vld, rd_last;
  logic [AXIS_BITS-1:0]   rd_x, rd_y, rd_z;
  logic [RAND_BITS-1:0]   rnd;
  logic [TOTAL_BITS-1:0]  total;
  logic [PROD_BITS-1:0]   prod;

  logic                   accept, wr_hit, scan_last;
  logic                   ram_we;
  logic [ADDR_BITS-1:0]   ram_waddr, ram_raddr;
  logic [WEIGHT_BITS-1:0] ram_wdata, ram_rdata;
  logic [TOTAL_BITS-1:0]  acc_sum;
  logic                   acc_hit;
  acc_ctl_t               acc_ctl;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign wr_hit   = accept && (item.action == ACT_WRITE) &&
                    (item.x <= dims.lx) && (item.y <= dims.ly) && (item.z <= dims.lz);

  assign ram_we    = (state == ST_CLEAR) || wr_hit;
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : {item.x, item.y, item.z};
  assign ram_wdata = (state == ST_CLEAR) ? '0 : item.weight;
  assign ram_raddr = {cx, cy, cz};
  assign scan_last = (cx == dims.lx) && (cy == dims.ly) && (cz == dims.lz);

  assign acc_ctl.clear = (accept && (item.action == ACT_DRAW)) || (state == ST_MUL);
  assign acc_ctl.add   = rd_vld && ((state == ST_SUM) || (state == ST_SEARCH));

  assign stat.clearing = (state == ST_CLEAR);
  assign stat.idle     = (state == ST_IDLE);
  assign stat.done     = (state == ST_DONE);

  vws_ram #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (WEIGHT_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  vws_accum u_accum (
    .clk    (clk),
    .ctl    (acc_ctl),
    .data   (ram_rdata),
    .thresh (prod[PROD_BITS-1:RAND_BITS]),
    .sum    (acc_sum),
    .hit    (acc_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      issuing  <= 1'b0;
      rd_vld   <= 1'b0;
    end else begin
      rd_vld  <= issuing;
      rd_last <= scan_last;
      rd_x    <= cx;
      rd_y    <= cy;
      rd_z    <= cz;
      // z innermost, x outermost
      if (issuing) begin
        if (scan_last) begin
          issuing <= 1'b0;
        end
        if (cz == dims.lz) begin
          cz <= '0;
          if (cy == dims.ly) begin
            cy <= '0;
            cx <= cx + 1'b1;
          end else begin
            cy <= cy + 1'b1;
          end
        end else begin
          cz <= cz + 1'b1;
        end
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_BITS'(STORE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (item.action == ACT_DRAW)) begin
            rnd     <= item.rnd;
            issuing <= 1'b1;
            cx      <= '0;
            cy      <= '0;
            cz      <= '0;
            state   <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (rd_vld && rd_last) begin
            total <= acc_sum;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod    <= {{TOTAL_BITS{1'b0}}, rnd} * {{RAND_BITS{1'b0}}, total};
          issuing <= 1'b1;
          cx      <= '0;
          cy      <= '0;
          cz      <= '0;
          state   <= ST_SEARCH;
        end
        ST_SEARCH: begin
          // the full total always reaches the threshold, so a hit comes
          if (rd_vld && acc_hit) begin
            res.x    <= rd_x;
            res.y    <= rd_y;
            res.z    <= rd_z;
            res.zero <= (total == '0);
            issuing  <= 1'b0;
            state    <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ack) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
